/* rtl/core/entropy_health_monitor_macros.svh */
// Assertion macros for the entropy health monitor.
`ifndef ENTROPY_HEALTH_MONITOR_MACROS_SVH
`define ENTROPY_HEALTH_MONITOR_MACROS_SVH

`ifndef SYNTH

`define EHM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("entropy health monitor assertion failed");

`define EHM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("entropy health monitor assertion failed");

`else

`define EHM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define EHM_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* rtl/core/ehm_pkg.sv */
package ehm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RUN_W    = 8;
    localparam int COUNT_W  = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_REPEAT   = 2'd1;
    localparam status_t STATUS_ADAPTIVE = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_REPEAT_CUTOFF     = 2'd0;
    localparam cfg_index_t CFG_PROPORTION_CUTOFF = 2'd1;
    localparam cfg_index_t CFG_WINDOW_LENGTH     = 2'd2;

    localparam logic [RUN_W-1:0]   REPEAT_CUTOFF_RST     = 8'd21;
    localparam logic [COUNT_W-1:0] PROPORTION_CUTOFF_RST = 13'd410;
    localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RST     = 13'd512;

endpackage

/* rtl/core/ehm_channels.sv */
interface ehm_sample_if
    import ehm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface ehm_status_if
    import ehm_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t health_status;

    modport source (output valid, output health_status, input ready);
    modport sink (input valid, input health_status, output ready);
endinterface

/* rtl/core/entropy_health_monitor.sv */
// Continuous health monitor for a raw noise source, running the repetition count and
// adaptive proportion tests on every sample. Each sample beat yields exactly one status
// beat: 0 ok, 1 repetition failure, 2 adaptive proportion failure (which wins over a
// repetition failure). The first sample after reset only seeds the tests and reports ok.
// One sample is taken every cycle while the status side keeps up. A status passes through
// the input register and then the status register, with the test state updated in the
// single stage between them. While the status side stalls, the block holds two beats and
// then holds off the input.
// Only the low SAMPLE_BITS bits of a sample, at most SAMPLE_W, are compared.
// The cutoff and window registers may be written only while no beat is in flight.
`include "entropy_health_monitor_macros.svh"

module entropy_health_monitor
    import ehm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  cfg_index_t           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    ehm_sample_if.sink           samples,
    ehm_status_if.source         results
);

    localparam int CMP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    logic [RUN_W-1:0]   repeat_cutoff_reg;
    logic [COUNT_W-1:0] proportion_cutoff_reg;
    logic [COUNT_W-1:0] window_length_reg;

    logic                in_valid_reg;
    logic [CMP_BITS-1:0] in_sample_reg;

    logic                seeded_reg, seeded_next;
    logic [CMP_BITS-1:0] previous_sample_reg, previous_sample_next;
    logic [RUN_W-1:0]    run_length_reg, run_length_next;
    logic [CMP_BITS-1:0] reference_sample_reg, reference_sample_next;
    logic [COUNT_W-1:0]  match_count_reg, match_count_next;
    logic [COUNT_W-1:0]  window_position_reg, window_position_next;

    logic    out_valid_reg;
    status_t status_reg, status_next;

    logic             out_free;
    logic             fire;
    logic [COUNT_W:0] position_inc;

    assign out_free      = !out_valid_reg || results.ready;
    assign fire          = in_valid_reg && out_free;
    assign samples.ready = !in_valid_reg || out_free;
    assign results.valid = out_valid_reg;
    assign results.health_status = status_reg;
    assign position_inc  = {1'b0, window_position_reg} + {{COUNT_W{1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_cutoff_reg     <= REPEAT_CUTOFF_RST;
            proportion_cutoff_reg <= PROPORTION_CUTOFF_RST;
            window_length_reg     <= WINDOW_LENGTH_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_REPEAT_CUTOFF:     repeat_cutoff_reg     <= cfg_data[RUN_W-1:0];
                CFG_PROPORTION_CUTOFF: proportion_cutoff_reg <= cfg_data[COUNT_W-1:0];
                CFG_WINDOW_LENGTH:     window_length_reg     <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        seeded_next           = seeded_reg;
        previous_sample_next  = previous_sample_reg;
        run_length_next       = run_length_reg;
        reference_sample_next = reference_sample_reg;
        match_count_next      = match_count_reg;
        window_position_next  = window_position_reg;
        status_next           = STATUS_OK;

        if (!seeded_reg)
        begin
            seeded_next           = 1'b1;
            previous_sample_next  = in_sample_reg;
            run_length_next       = {{(RUN_W-1){1'b0}}, 1'b1};
            reference_sample_next = in_sample_reg;
            match_count_next      = {{(COUNT_W-1){1'b0}}, 1'b1};
            window_position_next  = {{(COUNT_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            if (in_sample_reg == previous_sample_reg)
            begin
                if (run_length_reg < repeat_cutoff_reg)
                begin
                    run_length_next = run_length_reg + {{(RUN_W-1){1'b0}}, 1'b1};
                end
                if (run_length_next >= repeat_cutoff_reg)
                begin
                    status_next = STATUS_REPEAT;
                end
            end
            else
            begin
                previous_sample_next = in_sample_reg;
                run_length_next      = {{(RUN_W-1){1'b0}}, 1'b1};
            end

            if (in_sample_reg == reference_sample_reg)
            begin
                if (match_count_reg < proportion_cutoff_reg)
                begin
                    match_count_next = match_count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                end
                if (match_count_next >= proportion_cutoff_reg)
                begin
                    status_next = STATUS_ADAPTIVE;
                end
            end

            if (position_inc >= {1'b0, window_length_reg} || position_inc[COUNT_W])
            begin
                reference_sample_next = in_sample_reg;
                match_count_next      = {{(COUNT_W-1){1'b0}}, 1'b1};
                window_position_next  = '0;
            end
            else
            begin
                window_position_next = position_inc[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            seeded_reg           <= 1'b0;
            previous_sample_reg  <= '0;
            run_length_reg       <= '0;
            reference_sample_reg <= '0;
            match_count_reg      <= '0;
            window_position_reg  <= '0;
        end
        else
        begin
            if (samples.ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (fire)
            begin
                out_valid_reg        <= 1'b1;
                seeded_reg           <= seeded_next;
                previous_sample_reg  <= previous_sample_next;
                run_length_reg       <= run_length_next;
                reference_sample_reg <= reference_sample_next;
                match_count_reg      <= match_count_next;
                window_position_reg  <= window_position_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            in_sample_reg <= samples.sample[CMP_BITS-1:0];
        end
        if (fire)
        begin
            status_reg <= status_next;
        end
    end

    `EHM_ASSERT_IMPLIES(a_status_code, clk, rst_n, results.valid,
        results.health_status == STATUS_OK || results.health_status == STATUS_REPEAT ||
        results.health_status == STATUS_ADAPTIVE)
    `EHM_ASSERT_NEXT(a_seed_reports_ok, clk, rst_n, fire && !seeded_reg,
        out_valid_reg && status_reg == STATUS_OK && seeded_reg)
    `EHM_ASSERT_IMPLIES(a_counts_live, clk, rst_n, seeded_reg,
        run_length_reg != '0 && match_count_reg != '0)
    `EHM_ASSERT_IMPLIES(a_position_bound, clk, rst_n, 1'b1,
        window_position_reg != {COUNT_W{1'b1}})

endmodule
